// File: hw/rtl/pts_pkg.sv
// Package for the periodic task tick scheduler: widths, command, mode and
// status codes, and the control and status bundles between its modules.
// Depends on nothing.
package pts_pkg;

  // Table size and result limits.
  localparam int MAX_TASKS_DEF = 8;
  localparam int RESULT_LIMIT  = 8;
  localparam int FOUND_W       = $clog2(RESULT_LIMIT + 1);

  // Field widths.
  localparam int CMD_W     = 2;
  localparam int PERIOD_W  = 8;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 3;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_MAX_PERIOD = 1'b0;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 8'd255;

  // Value loaded into a tick counter at creation and after a period ends.
  localparam logic [PERIOD_W-1:0] COUNTER_INIT = 8'd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXEC   = 2'd2;

  // Task modes.
  localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READY     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUSPENDED = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_COUNT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PERIOD = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the input transaction, clear walk state
    logic create;     // check and append a task, load its result
    logic read;       // read the table entry at the walk index
    logic tick_wb;    // write back the ticked entry
    logic exec_take;  // mark the entry idle, emit the held result
    logic step;       // advance the walk index
    logic flush;      // load the closing result
  } pts_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             no_tasks;
    logic             at_last;
    logic             entry_ready;
    logic             pend_valid;
    logic             found_limit;
    logic             out_free;
  } pts_sts_t;

endpackage

// File: hw/rtl/pts_if.sv
// Handshake interfaces for the scheduler's command and result channels.
// Depends on pts_pkg for field widths.
interface pts_req_if;
  logic                          valid;
  logic                          ready;
  logic [pts_pkg::CMD_W-1:0]     cmd;
  logic                          has_function;
  logic [pts_pkg::PERIOD_W-1:0]  period;
  logic [pts_pkg::MODE_W-1:0]    initial_state;

  modport source (output valid, cmd, has_function, period, initial_state, input ready);
  modport sink   (input valid, cmd, has_function, period, initial_state, output ready);
endinterface

interface pts_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pts_pkg::STATUS_W-1:0]   status;
  logic [pts_pkg::OUT_IDX_W-1:0]  task_index;
  logic                           run_valid;
  logic                           last;

  modport source (output valid, status, task_index, run_valid, last, input ready);
  modport sink   (input valid, status, task_index, run_valid, last, output ready);
endinterface

// File: hw/rtl/pts_datapath.sv
// Datapath of the scheduler: task table memory, walk index, held result,
// output register and the max_period register.
// Depends on pts_pkg.
module pts_datapath #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pts_pkg::pts_ctl_t               ctl,
  output pts_pkg::pts_sts_t               sts,
  input  logic [pts_pkg::CMD_W-1:0]       cmd,
  input  logic                            has_function,
  input  logic [pts_pkg::PERIOD_W-1:0]    period,
  input  logic [pts_pkg::MODE_W-1:0]      initial_state,
  input  logic                            cfg_we,
  input  logic [pts_pkg::PERIOD_W-1:0]    cfg_data,
  output logic [pts_pkg::PERIOD_W-1:0]    max_period,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pts_pkg::STATUS_W-1:0]    status,
  output logic [pts_pkg::OUT_IDX_W-1:0]   task_index,
  output logic                            run_valid,
  output logic                            last
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  typedef struct packed {
    logic [pts_pkg::PERIOD_W-1:0] per;
    logic [pts_pkg::PERIOD_W-1:0] counter;
    logic [pts_pkg::MODE_W-1:0]   mode;
  } entry_t;

  // Slot number as shown on the result, kept to its low three bits.
  function automatic logic [pts_pkg::OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] s);
    logic [IDX_W+pts_pkg::OUT_IDX_W-1:0] w;
    w = (IDX_W + pts_pkg::OUT_IDX_W)'(s);
    return w[pts_pkg::OUT_IDX_W-1:0];
  endfunction

  entry_t mem [MAX_TASKS];
  entry_t rd_q;

  logic [pts_pkg::CMD_W-1:0]    cmd_q;
  logic                         has_fn_q;
  logic [pts_pkg::PERIOD_W-1:0] per_q;
  logic [pts_pkg::MODE_W-1:0]   init_q;
  logic [CNT_W-1:0]             task_count;
  logic [IDX_W-1:0]             idx;
  logic [IDX_W-1:0]             pend_idx;
  logic                         pend_valid;
  logic [pts_pkg::FOUND_W-1:0]  found;

  logic [pts_pkg::STATUS_W-1:0] create_status;
  logic                         create_ok;
  logic                         full;
  logic                         tick_hit;
  logic                         we;
  logic [IDX_W-1:0]             waddr;
  entry_t                       wdata;
  logic                         out_load;
  logic [pts_pkg::STATUS_W-1:0] status_next;
  logic [pts_pkg::OUT_IDX_W-1:0] task_index_next;
  logic                         run_valid_next;
  logic                         last_next;

  // Creation checks, in priority order.
  assign full = (task_count == CNT_W'(MAX_TASKS));

  always_comb begin
    priority if (!has_fn_q) begin
      create_status = pts_pkg::ST_NULL;
    end else if (full) begin
      create_status = pts_pkg::ST_COUNT;
    end else if (per_q > max_period) begin
      create_status = pts_pkg::ST_PERIOD;
    end else begin
      create_status = pts_pkg::ST_OK;
    end
  end

  assign create_ok = (create_status == pts_pkg::ST_OK);

  // Table write: a new task, a ticked entry, or an executed entry going idle.
  assign tick_hit = (rd_q.counter >= rd_q.per);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd_q;
    if (ctl.create) begin
      we    = create_ok;
      waddr = task_count[IDX_W-1:0];
      wdata = '{per: per_q, counter: pts_pkg::COUNTER_INIT, mode: init_q};
    end else if (ctl.tick_wb) begin
      we = (rd_q.mode != pts_pkg::MODE_SUSPENDED);
      if (tick_hit) begin
        wdata.counter = pts_pkg::COUNTER_INIT;
        wdata.mode    = pts_pkg::MODE_READY;
      end else begin
        wdata.counter = rd_q.counter + 8'd1;
      end
    end else if (ctl.exec_take) begin
      we         = 1'b1;
      wdata.mode = pts_pkg::MODE_IDLE;
    end
  end

  // Task table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.read) begin
      rd_q <= mem[idx];
    end
  end

  // Captured transaction fields.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q    <= cmd;
      has_fn_q <= has_function;
      per_q    <= period;
      init_q   <= initial_state;
    end
    if (ctl.exec_take) begin
      pend_idx <= idx;
    end
  end

  // Walk state, task count and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_period <= pts_pkg::MAX_PERIOD_RST;
      task_count <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
      found      <= '0;
    end else begin
      if (cfg_we) begin
        max_period <= cfg_data;
      end
      if (ctl.create && create_ok) begin
        task_count <= task_count + CNT_W'(1);
      end
      if (ctl.latch) begin
        idx        <= '0;
        pend_valid <= 1'b0;
        found      <= '0;
      end else begin
        if (ctl.step) begin
          idx <= idx + IDX_W'(1);
        end
        if (ctl.exec_take) begin
          pend_valid <= 1'b1;
          found      <= found + pts_pkg::FOUND_W'(1);
        end
      end
    end
  end

  // Next result: a creation outcome, a held ready task, or the closing one.
  assign out_load = ctl.create || (ctl.exec_take && pend_valid) || ctl.flush;

  always_comb begin
    status_next     = pts_pkg::ST_OK;
    task_index_next = '0;
    run_valid_next  = 1'b0;
    last_next       = 1'b1;
    if (ctl.create) begin
      status_next     = create_status;
      task_index_next = create_ok ? to_out_idx(task_count[IDX_W-1:0]) : '0;
    end else if (ctl.exec_take) begin
      task_index_next = to_out_idx(pend_idx);
      run_valid_next  = 1'b1;
      last_next       = 1'b0;
    end else if (pend_valid) begin
      task_index_next = to_out_idx(pend_idx);
      run_valid_next  = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= status_next;
      task_index <= task_index_next;
      run_valid  <= run_valid_next;
      last       <= last_next;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.cmd         = cmd_q;
    sts.no_tasks    = (task_count == '0);
    sts.at_last     = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(task_count);
    sts.entry_ready = (rd_q.mode == pts_pkg::MODE_READY);
    sts.pend_valid  = pend_valid;
    sts.found_limit = (found == pts_pkg::FOUND_W'(pts_pkg::RESULT_LIMIT - 1));
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

// File: hw/rtl/pts_ctrl.sv
// Controller of the scheduler: sequences create, the tick walk and the
// execute walk over the task table, with a read state and a process state per entry.
// Depends on pts_pkg.
module pts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  pts_pkg::pts_sts_t sts,
  output pts_pkg::pts_ctl_t ctl
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_CREATE   = 6'b000100,
    S_READ     = 6'b001000,
    S_PROC     = 6'b010000,
    S_FLUSH    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          pts_pkg::CMD_CREATE: state_next = S_CREATE;
          pts_pkg::CMD_TICK,
          pts_pkg::CMD_EXEC:   state_next = sts.no_tasks ? S_FLUSH : S_READ;
          default:             state_next = S_FLUSH;
        endcase
      end
      S_CREATE: begin
        if (sts.out_free) begin
          ctl.create = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        ctl.read   = 1'b1;
        state_next = S_PROC;
      end
      S_PROC: begin
        if (sts.cmd == pts_pkg::CMD_TICK) begin
          ctl.tick_wb = 1'b1;
          if (sts.at_last) begin
            state_next = S_FLUSH;
          end else begin
            ctl.step   = 1'b1;
            state_next = S_READ;
          end
        end else if (sts.entry_ready) begin
          // A held result goes out only when the output register can take it.
          if (!sts.pend_valid || sts.out_free) begin
            ctl.exec_take = 1'b1;
            if (sts.at_last || sts.found_limit) begin
              state_next = S_FLUSH;
            end else begin
              ctl.step   = 1'b1;
              state_next = S_READ;
            end
          end
        end else if (sts.at_last) begin
          state_next = S_FLUSH;
        end else begin
          ctl.step   = 1'b1;
          state_next = S_READ;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          ctl.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler: controller, datapath and
// the configuration register port. Depends on pts_pkg, pts_if, pts_ctrl, pts_datapath.
//
//   Channel   Kind         Direction  Carries
//   req       valid/ready  in         cmd, has_function, period, initial_state
//   rsp       valid/ready  out        status, task_index, run_valid, last
//   apb       psel/penable in         max_period register (byte address 0)
//
// A create passes through the dispatch and create states. A tick or execute
// walks the task table, which has one registered read port, so each entry
// takes a read state and a process state. An execute emits one result per ready
// task, at most eight. Reset is synchronous and empties the task table.
// A new transaction is taken while the last result still waits in the
// output register; a stalled output holds the walk at its next result.
module periodic_task_tick_scheduler #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  pts_req_if.sink                       req,
  pts_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pts_pkg::PADDR_W-1:0]   paddr,
  input  logic [pts_pkg::PDATA_W-1:0]   pwdata,
  output logic [pts_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  pts_pkg::pts_ctl_t              ctl;
  pts_pkg::pts_sts_t              sts;
  logic                           cfg_we;
  logic [pts_pkg::PERIOD_W-1:0]   max_period;

  // Register access.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[pts_pkg::PADDR_W-1:2] == pts_pkg::REG_MAX_PERIOD);
  assign prdata = (paddr[pts_pkg::PADDR_W-1:2] == pts_pkg::REG_MAX_PERIOD) ?
                  pts_pkg::PDATA_W'(max_period) : '0;

  pts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (req.valid),
    .item_ready (req.ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  pts_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cmd           (req.cmd),
    .has_function  (req.has_function),
    .period        (req.period),
    .initial_state (req.initial_state),
    .cfg_we        (cfg_we),
    .cfg_data      (pwdata[pts_pkg::PERIOD_W-1:0]),
    .max_period    (max_period),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .task_index    (rsp.task_index),
    .run_valid     (rsp.run_valid),
    .last          (rsp.last)
  );

endmodule

// File: hw/rtl/pts_checker.sv
// Port-level checks for the periodic task tick scheduler, bound to its top.
// Depends on pts_pkg and periodic_task_tick_scheduler.
module pts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [pts_pkg::STATUS_W-1:0]    status,
  input logic [pts_pkg::OUT_IDX_W-1:0]   task_index,
  input logic                            run_valid,
  input logic                            last
);

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // Only a run result can be followed by more results of the same transaction.
  a_norun_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !run_valid |-> last)
    else $error("non-run result without last");

  // An error result names no slot and no task to run.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != pts_pkg::ST_OK) |-> !run_valid && (task_index == '0))
    else $error("error result carries a slot or a run");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result offered right after reset");

endmodule

bind periodic_task_tick_scheduler pts_checker u_pts_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .task_index (rsp.task_index),
  .run_valid  (rsp.run_valid),
  .last       (rsp.last)
);

// File: test/tb.sv
// Self-checking testbench for periodic_task_tick_scheduler: directed table, then
// random command phases under several max_period settings, with handshake stalls.
// Depends on pts_pkg, pts_if and the scheduler RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  localparam int TASKS      = MAX_TASKS_DEF;
  localparam int WDOG_LIMIT = 3000;
  localparam int HOLD_LEN   = 80;
  localparam int PHASE_LEN  = 20;
  localparam logic [CMD_W-1:0]   CMD_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0]  MODE_SPARE = 2'd3;
  localparam logic [PADDR_W-1:0] MAXP_ADDR  = PADDR_W'(4 * REG_MAX_PERIOD);

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic                has_function;
    logic [PERIOD_W-1:0] period;
    logic [MODE_W-1:0]   initial_state;
  } sched_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] task_index;
    logic                 run_valid;
    logic                 last;
  } sched_rsp_t;

  typedef struct packed {
    logic                is_cfg;
    logic [PERIOD_W-1:0] cfg_val;
    sched_cmd_t          c;
    logic                has_lit;
    sched_rsp_t          lit;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  pts_req_if req_ch();
  pts_rsp_if rsp_ch();

  periodic_task_tick_scheduler dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted scheduler state and the results still owed by the block.
  int                  sch_count;
  logic [PERIOD_W-1:0] sch_max_period;
  logic [PERIOD_W-1:0] sch_period  [TASKS];
  logic [PERIOD_W-1:0] sch_counter [TASKS];
  logic [MODE_W-1:0]   sch_mode    [TASKS];
  sched_rsp_t          due_results [$];

  int  mismatches = 0;
  int  n_cmds = 0;
  int  n_checked = 0;
  int  n_runs = 0;
  int  hold_cycles = 0;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  int  quiet_cycles = 0;

  stim_row_t dir_rows [$];

  function automatic sched_rsp_t closing(input logic [STATUS_W-1:0] st,
                                         input logic [OUT_IDX_W-1:0] idx);
    closing = '{st, idx, 1'b0, 1'b1};
  endfunction

  function automatic stim_row_t cmd_row(input logic [CMD_W-1:0] cmd, input logic fn,
                                        input logic [PERIOD_W-1:0] per,
                                        input logic [MODE_W-1:0] init,
                                        input logic lit_on, input sched_rsp_t lit);
    cmd_row = '{1'b0, 8'd0, '{cmd, fn, per, init}, lit_on, lit};
  endfunction

  function automatic stim_row_t cfg_row(input logic [PERIOD_W-1:0] v);
    cfg_row = '{1'b1, v, '0, 1'b0, '0};
  endfunction

  // Apply one command to the predicted table and queue the results it owes.
  function automatic void predict_schedule(input sched_cmd_t c);
    int         n;
    sched_rsp_t r;
    case (c.cmd)
      CMD_CREATE: begin
        if (!c.has_function) begin
          due_results.push_back(closing(ST_NULL, '0));
        end else if (sch_count >= TASKS) begin
          due_results.push_back(closing(ST_COUNT, '0));
        end else if (c.period > sch_max_period) begin
          due_results.push_back(closing(ST_PERIOD, '0));
        end else begin
          sch_period[sch_count]  = c.period;
          sch_mode[sch_count]    = c.initial_state;
          sch_counter[sch_count] = COUNTER_INIT;
          due_results.push_back(closing(ST_OK, OUT_IDX_W'(sch_count)));
          sch_count++;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < sch_count; i++) begin
          if (sch_mode[i] != MODE_SUSPENDED) begin
            if (sch_counter[i] >= sch_period[i]) begin
              sch_mode[i]    = MODE_READY;
              sch_counter[i] = COUNTER_INIT;
            end else begin
              sch_counter[i] = sch_counter[i] + 8'd1;
            end
          end
        end
        due_results.push_back(closing(ST_OK, '0));
      end
      CMD_EXEC: begin
        n = 0;
        for (int i = 0; i < sch_count && n < RESULT_LIMIT; i++) begin
          if (sch_mode[i] == MODE_READY) begin
            sch_mode[i] = MODE_IDLE;
            r = '{ST_OK, OUT_IDX_W'(i), 1'b1, 1'b0};
            due_results.push_back(r);
            n++;
          end
        end
        // The final run result closes the transaction; none ready gives one empty result.
        if (n == 0) begin
          due_results.push_back(closing(ST_OK, '0));
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
      end
      default: begin
        due_results.push_back(closing(ST_OK, '0));
      end
    endcase
  endfunction

  // Random command: mostly ticks and executes, with creates and the spare code mixed in.
  function automatic sched_cmd_t rand_cmd();
    sched_cmd_t c;
    int         pick;
    pick = $urandom_range(0, 99);
    c.cmd = (pick < 40) ? CMD_TICK : (pick < 70) ? CMD_EXEC :
            (pick < 92) ? CMD_CREATE : CMD_SPARE;
    c.has_function  = ($urandom_range(0, 9) != 0);
    c.period        = ($urandom_range(0, 4) < 3) ? PERIOD_W'($urandom_range(0, 6)) :
                                                   PERIOD_W'($urandom_range(0, 255));
    c.initial_state = MODE_W'($urandom_range(0, 3));
    return c;
  endfunction

  // Offer one command and wait for the transaction; valid stays high afterward.
  task automatic offer(input sched_cmd_t c, input logic lit_on, input sched_rsp_t lit);
    int n_prior;
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= c.cmd;
    req_ch.has_function  <= c.has_function;
    req_ch.period        <= c.period;
    req_ch.initial_state <= c.initial_state;
    do @(posedge clk); while (!req_ch.ready);
    n_prior = due_results.size();
    predict_schedule(c);
    if (lit_on) begin
      while (due_results.size() > n_prior) void'(due_results.pop_back());
      due_results.push_back(lit);
    end
    n_cmds++;
  endtask

  task automatic maybe_gap();
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every owed result has come back.
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic check_max_period(input logic [PERIOD_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAXP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== PDATA_W'(v)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: max_period read %h, expected %h", prdata, PDATA_W'(v));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_max_period(input logic [PERIOD_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAXP_ADDR;
    pwdata  <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    // The access phase ends at the first edge with pready high.
    do @(posedge clk); while (!pready);
    sch_max_period = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_max_period(v);
  endtask

  // Result side: random stall bursts, plus one long hold-off when asked.
  initial begin
    rsp_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        rsp_ch.ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest owed result.
  always @(posedge clk) begin
    sched_rsp_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.status, rsp_ch.task_index, rsp_ch.run_valid, rsp_ch.last};
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result st=%0d idx=%0d run=%0d last=%0d",
                   got.status, got.task_index, got.run_valid, got.last);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (want.run_valid) n_runs++;
        if (got.status !== want.status || got.task_index !== want.task_index ||
            got.run_valid !== want.run_valid || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: result mismatch: got st=%0d idx=%0d run=%0d last=%0d, %s%0d %0d %0d %0d",
                     got.status, got.task_index, got.run_valid, got.last,
                     "expected ", want.status, want.task_index, want.run_valid, want.last);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("tb: watchdog expired with %0d results owed", due_results.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Main stimulus.
  initial begin
    logic [PERIOD_W-1:0] pmax;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.cmd           <= CMD_TICK;
    req_ch.has_function  <= 1'b0;
    req_ch.period        <= '0;
    req_ch.initial_state <= MODE_IDLE;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    sch_count      = 0;
    sch_max_period = MAX_PERIOD_RST;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    check_max_period(MAX_PERIOD_RST);

    // Directed: empty table, error priority, period extremes, mode code 3, ready runs.
    dir_rows = '{
      cmd_row(CMD_EXEC,   1'b0, 8'd0,   MODE_IDLE,      1'b1, closing(ST_OK, 3'd0)),
      cmd_row(CMD_TICK,   1'b0, 8'd0,   MODE_IDLE,      1'b1, closing(ST_OK, 3'd0)),
      cmd_row(CMD_SPARE,  1'b1, 8'd255, MODE_SPARE,     1'b1, closing(ST_OK, 3'd0)),
      cmd_row(CMD_CREATE, 1'b0, 8'd255, MODE_IDLE,      1'b1, closing(ST_NULL, 3'd0)),
      cmd_row(CMD_CREATE, 1'b1, 8'd255, MODE_IDLE,      1'b1, closing(ST_OK, 3'd0)),
      cmd_row(CMD_CREATE, 1'b1, 8'd0,   MODE_READY,     1'b1, closing(ST_OK, 3'd1)),
      cfg_row(8'd0),
      cmd_row(CMD_CREATE, 1'b1, 8'd1,   MODE_IDLE,      1'b1, closing(ST_PERIOD, 3'd0)),
      cmd_row(CMD_CREATE, 1'b1, 8'd0,   MODE_SUSPENDED, 1'b1, closing(ST_OK, 3'd2)),
      cfg_row(8'd3),
      cmd_row(CMD_CREATE, 1'b1, 8'd3,   MODE_SPARE,     1'b1, closing(ST_OK, 3'd3)),
      cmd_row(CMD_CREATE, 1'b1, 8'd4,   MODE_READY,     1'b1, closing(ST_PERIOD, 3'd0)),
      cmd_row(CMD_CREATE, 1'b0, 8'd4,   MODE_READY,     1'b1, closing(ST_NULL, 3'd0)),
      cmd_row(CMD_EXEC,   1'b0, 8'd0,   MODE_IDLE,      1'b0, '0),
      cmd_row(CMD_TICK,   1'b0, 8'd0,   MODE_IDLE,      1'b1, closing(ST_OK, 3'd0)),
      cmd_row(CMD_TICK,   1'b1, 8'd170, MODE_READY,     1'b1, closing(ST_OK, 3'd0)),
      cmd_row(CMD_TICK,   1'b0, 8'd85,  MODE_SPARE,     1'b1, closing(ST_OK, 3'd0)),
      cmd_row(CMD_EXEC,   1'b0, 8'd0,   MODE_IDLE,      1'b0, '0),
      cmd_row(CMD_EXEC,   1'b0, 8'd0,   MODE_IDLE,      1'b0, '0),
      cfg_row(8'd255)
    };
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        quiesce();
        set_max_period(dir_rows[k].cfg_val);
      end else begin
        maybe_gap();
        offer(dir_rows[k].c, dir_rows[k].has_lit, dir_rows[k].lit);
      end
    end

    // Random phases: each starts from an idle block with a new max_period.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: pmax = 8'd255;
        1: pmax = 8'd0;
        4: pmax = 8'd255;
        default: pmax = PERIOD_W'($urandom_range(1, 254));
      endcase
      quiesce();
      set_max_period(pmax);
      // Phase 1 keeps the result side blocked while commands pile up.
      tx_idle_en = (p != 1) && (p != 4);
      rx_idle_en = (p != 4);
      if (p == 1) hold_cycles = HOLD_LEN;
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (p == 2 && k == PHASE_LEN / 2) quiesce();
        maybe_gap();
        offer(rand_cmd(), 1'b0, '0);
      end
    end

    quiesce();
    repeat (30) @(posedge clk);
    $display("tb: %0d commands sent, %0d results checked, %0d task runs, %0d tasks created",
             n_cmds, n_checked, n_runs, sch_count);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
